### design/lqs_pkg.sv
// Shared constants and types for the linear queue with sort unit.
// Holds the queue depth, derived index widths, command and status codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lqs_pkg;

   // queue geometry
   localparam int DEPTH = 128;
   localparam int AW    = $clog2(DEPTH);      // slot index width
   localparam int CW    = $clog2(DEPTH + 1);  // count width, holds DEPTH itself

   typedef logic [1:0]  cmd_type;
   typedef logic [1:0]  status_type;
   typedef logic [31:0] word_type;

   // command codes
   localparam cmd_type CMD_ENQ  = 2'd0;
   localparam cmd_type CMD_DEQ  = 2'd1;
   localparam cmd_type CMD_SORT = 2'd2;

   // status codes
   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_FULL  = 2'd1;
   localparam status_type ST_EMPTY = 2'd2;

endpackage

`default_nettype wire

### design/linear_queue_with_sort_unit.sv
// Linear (non-circular) queue of signed 32-bit words with an in-memory bubble sort.
// Slots live in one synchronous RAM (one write, one registered read per cycle).
// Depends on lqs_pkg.
`timescale 1ns / 1ps
`default_nettype none

// A transaction is taken when start is high and busy is low; exactly one result
// follows on rsp_valid for one cycle and cannot be held off by the receiver.
// Enqueue answers the cycle after it is taken and leaves the unit free at once.
// Dequeue reads the slot RAM, then registers the word as the result.
// Sort of n live entries keeps busy high while it first moves the live entries
// down to slot 0 through the single RAM read port, then runs bubble passes; a
// pass over the first m+1 slots reloads slot 0, does m compare-and-write steps
// and writes the carried maximum. An empty sort answers the cycle after it is
// taken. The full status depends only on the tail having passed the last slot;
// dequeued slots are reclaimed only by a sort.
module linear_queue_with_sort_unit (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        start,
   output logic                       busy,
   input  wire lqs_pkg::cmd_type      req_cmd,
   input  wire lqs_pkg::word_type     req_value,
   output logic                       rsp_valid,
   output lqs_pkg::word_type          rsp_read_value,
   output lqs_pkg::status_type        rsp_status
);
   import lqs_pkg::*;

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DEQ  = 3'd1;
   localparam logic [2:0] S_COPY = 3'd2;
   localparam logic [2:0] S_LOAD = 3'd3;
   localparam logic [2:0] S_RUN  = 3'd4;
   localparam logic [2:0] S_END  = 3'd5;

   logic [2:0]      state_ff, state_in;
   logic [CW-1:0]   head_ff, head_in;
   logic [CW-1:0]   tail_ff, tail_in;
   logic [CW-1:0]   n_ff, n_in;          // live entry count of a sort
   logic [AW-1:0]   k_ff, k_in;          // copy position
   logic [AW-1:0]   j_ff, j_in;          // compare position within a pass
   logic [AW-1:0]   m_ff, m_in;          // last slot of the current pass
   word_type        carry_ff, carry_in;  // running maximum of the pass
   logic            rsp_valid_ff, rsp_valid_in;
   word_type        rsp_read_value_ff, rsp_read_value_in;
   status_type      rsp_status_ff, rsp_status_in;

   // slot ram ports
   word_type        slots_mem [DEPTH];
   word_type        rd_data_ff;
   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   word_type        wr_data;
   logic            rd_en;
   logic [AW-1:0]   rd_addr;

   logic            accept;
   logic            live;
   logic [CW-1:0]   n_live;
   logic [CW-1:0]   src_addr;
   logic [CW-1:0]   k_next;
   logic [AW-1:0]   j_next;

   assign accept   = start && !busy;
   assign live     = head_ff < tail_ff;
   assign n_live   = tail_ff - head_ff;
   assign k_next   = CW'(k_ff) + CW'(1);
   assign src_addr = head_ff + k_next;
   assign j_next   = j_ff + AW'(1);

   // slot ram: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slots_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= slots_mem[rd_addr];
      end
   end

   // command sequencer
   always_comb begin
      state_in          = state_ff;
      head_in           = head_ff;
      tail_in           = tail_ff;
      n_in              = n_ff;
      k_in              = k_ff;
      j_in              = j_ff;
      m_in              = m_ff;
      carry_in          = carry_ff;
      rsp_valid_in      = 1'b0;
      rsp_read_value_in = '0;
      rsp_status_in     = ST_OK;
      wr_en             = 1'b0;
      wr_addr           = '0;
      wr_data           = '0;
      rd_en             = 1'b0;
      rd_addr           = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  CMD_ENQ: begin
                     rsp_valid_in = 1'b1;
                     if (tail_ff == CW'(DEPTH)) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = tail_ff[AW-1:0];
                        wr_data = req_value;
                        tail_in = tail_ff + CW'(1);
                     end
                  end
                  CMD_DEQ: begin
                     if (live) begin
                        rd_en    = 1'b1;
                        rd_addr  = head_ff[AW-1:0];
                        head_in  = head_ff + CW'(1);
                        state_in = S_DEQ;
                     end else begin
                        rsp_valid_in      = 1'b1;
                        rsp_read_value_in = '1;
                        rsp_status_in     = ST_EMPTY;
                     end
                  end
                  CMD_SORT: begin
                     if (live) begin
                        n_in     = n_live;
                        k_in     = '0;
                        rd_en    = 1'b1;
                        rd_addr  = head_ff[AW-1:0];
                        state_in = S_COPY;
                     end else begin
                        head_in      = '0;
                        tail_in      = '0;
                        rsp_valid_in = 1'b1;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         // registered ram word becomes the result
         S_DEQ: begin
            rsp_valid_in      = 1'b1;
            rsp_read_value_in = rd_data_ff;
            state_in          = S_IDLE;
         end

         // move live entries down to slot 0, one per cycle
         S_COPY: begin
            wr_en   = 1'b1;
            wr_addr = k_ff;
            wr_data = rd_data_ff;
            if (k_next < n_ff) begin
               rd_en   = 1'b1;
               rd_addr = src_addr[AW-1:0];
               k_in    = k_next[AW-1:0];
            end else if (n_ff > CW'(1)) begin
               m_in     = AW'(n_ff - CW'(1));
               rd_en    = 1'b1;
               rd_addr  = '0;
               state_in = S_LOAD;
            end else begin
               head_in      = '0;
               tail_in      = n_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         // slot 0 starts the pass as the carried word
         S_LOAD: begin
            carry_in = rd_data_ff;
            rd_en    = 1'b1;
            rd_addr  = AW'(1);
            j_in     = '0;
            state_in = S_RUN;
         end

         // keep the larger word, write the smaller one back (swap only on greater)
         S_RUN: begin
            wr_en   = 1'b1;
            wr_addr = j_ff;
            if ($signed(carry_ff) > $signed(rd_data_ff)) begin
               wr_data = rd_data_ff;
            end else begin
               wr_data  = carry_ff;
               carry_in = rd_data_ff;
            end
            if (j_next < m_ff) begin
               rd_en   = 1'b1;
               rd_addr = j_next + AW'(1);
               j_in    = j_next;
            end else begin
               state_in = S_END;
            end
         end

         // carried maximum settles in the last slot of the pass
         S_END: begin
            wr_en   = 1'b1;
            wr_addr = m_ff;
            wr_data = carry_ff;
            if (m_ff > AW'(1)) begin
               m_in     = m_ff - AW'(1);
               rd_en    = 1'b1;
               rd_addr  = '0;
               state_in = S_LOAD;
            end else begin
               head_in      = '0;
               tail_in      = n_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      n_ff              <= n_in;
      k_ff              <= k_in;
      j_ff              <= j_in;
      m_ff              <= m_in;
      carry_ff          <= carry_in;
      rsp_read_value_ff <= rsp_read_value_in;
      rsp_status_ff     <= rsp_status_in;
   end

   assign busy           = state_ff != S_IDLE;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_status     = rsp_status_ff;

`ifndef SYNTHESIS
   // queue pointers stay ordered and within the slot array
   assert property (@(posedge clock) disable iff (reset)
      head_ff <= tail_ff && tail_ff <= CW'(DEPTH))
      else $error("queue pointers out of order");

   // ram never reads and writes the same slot in one cycle
   assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("slot ram read/write collision");

   // a dequeue from a non-empty queue answers once S_DEQ has registered the ram word
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd == CMD_DEQ && live) |-> ##2 rsp_valid)
      else $error("dequeue result missing");

   // empty status always carries the all-ones word
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_EMPTY) |-> (rsp_read_value == '1))
      else $error("empty dequeue word wrong");

   // no result follows a sort load or compare step
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RUN || state_ff == S_LOAD) |=> !rsp_valid)
      else $error("result during sort pass");
`endif

endmodule

`default_nettype wire
